### sv/vrps_pkg.sv
package vrps_pkg;

	// Sample, rate and position formats.
	localparam int SAMPLE_W = 24;
	localparam int RATE_W   = 17;
	localparam int FRAC_W   = 16;
	localparam int COUNT_W  = 40;
	localparam int POS_W    = COUNT_W + FRAC_W;

	// Product of a 25-bit tap difference and a 17-bit signed fraction.
	localparam int PROD_W = SAMPLE_W + 1 + FRAC_W + 1;

	// Rounding constant for the Q16 fraction (half an LSB of the output).
	localparam logic [FRAC_W-1:0] ROUND_HALF = 16'h8000;

	// A step of exactly one sample per sample puts the block in bypass.
	localparam logic [RATE_W-1:0] UNITY_STEP = 17'h10000;

	// Result queue that absorbs stalls on the output side.
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_AW    = 2;

	// APB data width.
	localparam int APB_DW = 32;

	// Register index (word address) of the rate register.
	localparam logic REG_RATE_STEP = 1'b0;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_in;
		logic signed [SAMPLE_W-1:0] right_in;
	} sample_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_out;
		logic signed [SAMPLE_W-1:0] right_out;
	} result_t;

endpackage

### sv/varispeed_ring_pitch_shifter.sv
// A result passes through the pipeline stages and the result queue before it is offered.
// Samples overlap in the pipeline, but both interpolation taps share the one read port of
// the sample ring, so a new sample is not taken while the previous one is in stage 1.
// Reset (arst_n, asynchronous): clears counts, read position and pipeline, and sets the
// rate to bypass. The ring is not cleared: reads are clamped to the span already written.
module varispeed_ring_pitch_shifter #(
	parameter int RING_DEPTH = 524288,
	parameter int CHANNELS   = 2
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            smp_valid,
	output logic                            smp_ready,
	input  vrps_pkg::sample_t               smp,
	output logic                            res_valid,
	input  logic                            res_ready,
	output vrps_pkg::result_t               res,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [2:0]                      paddr,
	input  logic [vrps_pkg::APB_DW-1:0]     pwdata,
	output logic [vrps_pkg::APB_DW-1:0]     prdata,
	output logic                            pready
);

	import vrps_pkg::*;

	localparam int AW    = $clog2(RING_DEPTH);
	localparam int RAM_W = CHANNELS * SAMPLE_W;

	localparam logic [AW-1:0]      DEPTH_LAST = AW'(RING_DEPTH - 1);
	localparam logic [AW:0]        DEPTH_M    = (AW + 1)'(RING_DEPTH);
	localparam logic [COUNT_W:0]   DEPTH_X    = (COUNT_W + 1)'(RING_DEPTH);

	// Configuration and persistent state.
	logic [RATE_W-1:0]  rate_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [AW-1:0]      wslot_q;
	logic [POS_W-1:0]   rpos_q;
	logic [AW-1:0]      rmod_q;
	logic               engaged_q;
	logic [OUTQ_AW:0]   inflight_q;

	logic smp_fire;
	logic res_fire;
	logic cfg_wr;
	logic pitch_c;

	// Accept-cycle arithmetic.
	logic [COUNT_W-1:0] wc_c;
	logic [AW-1:0]      wslot_n_c;
	logic [AW-1:0]      hmod_c;
	logic [POS_W-1:0]   pos_c;
	logic [AW-1:0]      pmod_c;
	logic [FRAC_W+1:0]  fr_sum_c;
	logic [1:0]         carry_c;
	logic [COUNT_W:0]   nidx_c;
	logic [POS_W-1:0]   newpos_c;
	logic [AW:0]        msum_c;
	logic [AW:0]        mred_c;
	logic [AW-1:0]      newmod_c;

	// Stage 1: clamp and tap addresses.
	logic               v_s1;
	logic [COUNT_W-1:0] idx_s1;
	logic [FRAC_W-1:0]  frac_s1;
	logic [AW-1:0]      pmod_s1;
	logic [COUNT_W-1:0] wc_s1;
	logic               full_s1;
	logic               gt2_s1;
	logic [AW-1:0]      minmod_s1;
	logic [AW-1:0]      hmod_s1;
	logic               pitch_s1;
	sample_t            smp_s1;
	logic               lt_c;
	logic               hi_c;
	logic [AW-1:0]      aaddr_c;
	logic [AW-1:0]      baddr_c;
	logic [FRAC_W-1:0]  fracx_c;

	// Stage 2: second tap read.
	logic               v_s2;
	logic [AW-1:0]      baddr_s2;
	logic [FRAC_W-1:0]  frac_s2;
	logic               pitch_s2;
	sample_t            smp_s2;

	// Stage 3: difference and multiply.
	logic               v_s3;
	logic [FRAC_W-1:0]  frac_s3;
	logic               pitch_s3;
	sample_t            smp_s3;

	// Stage 4: rounding and final add.
	logic               v_s4;
	logic               pitch_s4;
	sample_t            smp_s4;
	logic [SAMPLE_W-1:0] res_c [2];
	result_t            res_c4;

	// Ring ports.
	logic [RAM_W-1:0]   wr_data;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [RAM_W-1:0]   rd_data;

	// Handshakes. A sample is not taken while the previous one is in stage 1, and only with room reserved
	// in the result queue, so the pipeline itself never stalls.
	assign smp_ready = !v_s1 && (inflight_q < (OUTQ_AW + 1)'(OUTQ_DEPTH));
	assign smp_fire  = smp_valid && smp_ready;
	assign res_fire  = res_valid && res_ready;
	assign pitch_c   = (rate_q != UNITY_STEP);

	// APB register access.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_RATE_STEP) ? APB_DW'(rate_q) : '0;

	// Write slot tracks the sample count modulo the ring depth; the count itself
	// wraps at its full width, and the slot restarts with it.
	assign wc_c      = cnt_q + 1'b1;
	assign wslot_n_c = ((cnt_q == '1) || (wslot_q == DEPTH_LAST)) ? '0 : wslot_q + 1'b1;
	assign hmod_c    = (wslot_q == '0) ? DEPTH_LAST : wslot_q - 1'b1;

	// Read position for this sample: the held position, or the current sample on engaging.
	assign pos_c    = engaged_q ? rpos_q : {cnt_q, FRAC_W'(0)};
	assign pmod_c   = engaged_q ? rmod_q : wslot_q;
	assign fr_sum_c = {2'b00, pos_c[FRAC_W-1:0]} + {1'b0, rate_q};
	assign carry_c  = fr_sum_c[FRAC_W+1:FRAC_W];
	assign nidx_c   = {1'b0, pos_c[POS_W-1:FRAC_W]} + (COUNT_W + 1)'(carry_c);
	assign newpos_c = {nidx_c[COUNT_W-1:0], fr_sum_c[FRAC_W-1:0]};

	// The integer part moves by at most two, so its ring slot needs one wrap check.
	// When the integer part itself wraps, it is below the ring depth.
	assign msum_c   = {1'b0, pmod_c} + (AW + 1)'(carry_c);
	assign mred_c   = (msum_c >= DEPTH_M) ? msum_c - DEPTH_M : msum_c;
	assign newmod_c = nidx_c[COUNT_W] ? nidx_c[AW-1:0] : mred_c[AW-1:0];

	// Persistent state update on each accepted sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q    <= UNITY_STEP;
			cnt_q     <= '0;
			wslot_q   <= '0;
			rpos_q    <= '0;
			rmod_q    <= '0;
			engaged_q <= 1'b0;
		end else begin
			if (cfg_wr && (paddr[2] == REG_RATE_STEP)) begin
				rate_q <= pwdata[RATE_W-1:0];
			end
			if (smp_fire) begin
				cnt_q   <= wc_c;
				wslot_q <= wslot_n_c;
				if (pitch_c) begin
					rpos_q    <= newpos_c;
					rmod_q    <= newmod_c;
					engaged_q <= 1'b1;
				end else begin
					engaged_q <= 1'b0;
				end
			end
		end
	end

	// Count of samples accepted whose results have not been taken yet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			case ({smp_fire, res_fire})
				2'b10:   inflight_q <= inflight_q + 1'b1;
				2'b01:   inflight_q <= inflight_q - 1'b1;
				default: inflight_q <= inflight_q;
			endcase
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= smp_fire;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage payload registers.
	always_ff @(posedge clk) begin
		if (smp_fire) begin
			idx_s1    <= pos_c[POS_W-1:FRAC_W];
			frac_s1   <= pos_c[FRAC_W-1:0];
			pmod_s1   <= pmod_c;
			wc_s1     <= wc_c;
			full_s1   <= ({1'b0, wc_c} > DEPTH_X);
			gt2_s1    <= (wc_c > COUNT_W'(2));
			minmod_s1 <= wslot_n_c;
			hmod_s1   <= hmod_c;
			pitch_s1  <= pitch_c;
			smp_s1    <= smp;
		end
		if (v_s1) begin
			baddr_s2 <= baddr_c;
			frac_s2  <= fracx_c;
			pitch_s2 <= pitch_s1;
			smp_s2   <= smp_s1;
		end
		if (v_s2) begin
			frac_s3  <= frac_s2;
			pitch_s3 <= pitch_s2;
			smp_s3   <= smp_s2;
		end
		if (v_s3) begin
			pitch_s4 <= pitch_s3;
			smp_s4   <= smp_s3;
		end
	end

	// Clamp the read into the span still held. Below it, read the oldest sample;
	// past the newest pair, read the newest pair's first sample (or slot zero early on).
	// Only ring slots are needed: the clamp targets are fixed offsets from the write slot.
	assign lt_c = full_s1 && (({1'b0, idx_s1} + DEPTH_X) < {1'b0, wc_s1});
	assign hi_c = ({1'b0, idx_s1} + (COUNT_W + 1)'(2)) > {1'b0, wc_s1};

	always_comb begin
		if (lt_c) begin
			aaddr_c = minmod_s1;
		end else if (hi_c) begin
			aaddr_c = gt2_s1 ? hmod_s1 : '0;
		end else begin
			aaddr_c = pmod_s1;
		end
	end

	assign fracx_c = (lt_c || hi_c) ? '0 : frac_s1;
	assign baddr_c = (aaddr_c == DEPTH_LAST) ? '0 : aaddr_c + 1'b1;

	// Ring write data, one sample per stored channel.
	if (CHANNELS == 2) begin : g_wr2
		assign wr_data = {smp.right_in, smp.left_in};
	end else begin : g_wr1
		assign wr_data = smp.left_in;
	end

	// One read port: first tap in stage 1, second tap in stage 2. A sample is written
	// at its acceptance edge, before any read of it is issued, so no forwarding is needed.
	// The only same-cycle overlap is a second-tap read against the next write, and that
	// tap is then never the slot being written unless its weight is zero.
	assign rd_en   = (v_s1 && pitch_s1) || (v_s2 && pitch_s2);
	assign rd_addr = v_s1 ? aaddr_c : baddr_s2;

	vrps_ram #(
		.WIDTH(RAM_W),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (smp_fire),
		.waddr (wslot_q),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Per-channel linear interpolation: a + round((b - a) * f / 65536), rounding half up.
	for (genvar g = 0; g < 2; g++) begin : g_lane
		if (g < CHANNELS) begin : g_interp
			logic signed [SAMPLE_W-1:0]        a_s3;
			logic signed [SAMPLE_W-1:0]        a_s4;
			logic signed [SAMPLE_W-1:0]        b_c;
			logic signed [SAMPLE_W:0]          diff_c;
			logic signed [PROD_W-1:0]          prod_c;
			logic signed [PROD_W-1:0]          prod_s4;
			logic signed [PROD_W-1:0]          rnd_c;
			logic signed [PROD_W-FRAC_W-1:0]   q_c;
			logic signed [PROD_W-FRAC_W-1:0]   sum_c;

			// A zero weight ignores the second tap entirely.
			assign b_c    = rd_data[g*SAMPLE_W +: SAMPLE_W];
			assign diff_c = (frac_s3 == '0) ? '0
				: (SAMPLE_W + 1)'(b_c) - (SAMPLE_W + 1)'(a_s3);
			assign prod_c = diff_c * $signed({1'b0, frac_s3});

			assign rnd_c  = prod_s4 + PROD_W'(ROUND_HALF);
			assign q_c    = rnd_c[PROD_W-1:FRAC_W];
			assign sum_c  = q_c + (PROD_W - FRAC_W)'(a_s4);
			assign res_c[g] = sum_c[SAMPLE_W-1:0];

			always_ff @(posedge clk) begin
				if (v_s2) begin
					a_s3 <= rd_data[g*SAMPLE_W +: SAMPLE_W];
				end
				if (v_s3) begin
					prod_s4 <= prod_c;
					a_s4    <= a_s3;
				end
			end
		end else begin : g_pass
			assign res_c[g] = smp_s4.right_in;
		end
	end

	// Bypassed samples leave unchanged.
	assign res_c4.left_out  = pitch_s4 ? res_c[0] : smp_s4.left_in;
	assign res_c4.right_out = pitch_s4 ? res_c[1] : smp_s4.right_in;

	vrps_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s4),
		.push_data (res_c4),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// The two tap reads of neighboring samples never compete for the read port.
	a_rd_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(v_s1 && v_s2))
		else $error("ring read port requested by two stages");

	// An accepted sample blocks acceptance in the following cycle.
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		smp_fire |=> (v_s1 && !smp_ready))
		else $error("sample accepted in the cycle after an acceptance");

	// Results in flight never exceed the queue space reserved for them.
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= (OUTQ_AW + 1)'(OUTQ_DEPTH))
		else $error("result credit overrun");

	// Tracked ring slots stay inside the ring.
	a_slot: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, wslot_q} < DEPTH_M) && ({1'b0, rmod_q} < DEPTH_M))
		else $error("ring slot out of range");

	// A bypassed sample disengages the pitch path.
	a_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		(smp_fire && !pitch_c) |=> !engaged_q)
		else $error("pitch path still engaged after bypass");

endmodule

### sv/vrps_ram.sv
module vrps_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 524288
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; a read of the entry being written returns the old data.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/vrps_outq.sv
module vrps_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  vrps_pkg::result_t push_data,
	output logic              res_valid,
	input  logic              res_ready,
	output vrps_pkg::result_t res
);

	import vrps_pkg::*;

	result_t              slot_q [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0]   wptr_q;
	logic [OUTQ_AW-1:0]   rptr_q;
	logic [OUTQ_AW:0]     fill_q;
	logic                 pop;

	assign res_valid = (fill_q != '0);
	assign res       = slot_q[rptr_q];
	assign pop       = res_valid && res_ready;

	// Pointers and fill level. The producer only pushes into reserved space.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_data;
		end
	end

endmodule

### tb/sv/testbench.sv
module testbench;
	import vrps_pkg::*;

	localparam int RING_SIZE      = 524288;
	localparam int RESULT_LATENCY = 5;
	localparam int IDLE_PERCENT   = 21;
	localparam int HOLD_CYCLES    = 120;
	localparam int RANDOM_ITEMS   = 1380;
	localparam int REPORT_LIMIT   = 10;

	// Register map and rate codes.
	localparam logic [2:0]        RATE_STEP_ADDR = {REG_RATE_STEP, 2'b00};
	localparam logic [RATE_W-1:0] RATE_HALF      = 17'd32768;
	localparam logic [RATE_W-1:0] RATE_FAST      = 17'd98304;
	localparam logic [RATE_W-1:0] RATE_STOPPED   = 17'd0;
	localparam logic [RATE_W-1:0] RATE_TOP       = 17'h1FFFF;

	localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 24'sh7FFFFF;
	localparam logic signed [SAMPLE_W-1:0] SMP_MIN = -24'sh800000;
	localparam logic signed [SAMPLE_W-1:0] SMP_ODD = 24'shAAAAAA;
	localparam logic signed [SAMPLE_W-1:0] SMP_EVN = 24'sh555555;

	// Tracks the ring, the read position and the rate, and predicts every output sample.
	class pitch_scoreboard;
		bit signed [SAMPLE_W-1:0] ring_left [RING_SIZE];
		bit signed [SAMPLE_W-1:0] ring_right [RING_SIZE];
		bit [COUNT_W-1:0] written_count;
		bit [POS_W-1:0]   read_pos;
		bit               engaged;
		bit [RATE_W-1:0]  rate = UNITY_STEP;
		result_t          pending_outputs[$];
		int failures;
		int reported;
		int pitched;
		int bypassed;

		function void report(string msg);
			failures++;
			if (reported < REPORT_LIMIT) begin
				reported++;
				$display("%0t: %s", $realtime, msg);
			end
		endfunction

		// Linear blend of two taps with the fraction rounded half up.
		function automatic logic signed [SAMPLE_W-1:0] blend(longint a, longint b, longint frac);
			longint t;
			t = (b - a) * frac + longint'(ROUND_HALF);
			return SAMPLE_W'(a + (t >>> FRAC_W));
		endfunction

		function void accept_sample(sample_t s);
			bit [COUNT_W-1:0] start;
			longint wc;
			longint lo;
			longint hi;
			longint idx;
			longint frac;
			longint p0;
			longint p1;
			result_t predicted;
			start = written_count;
			ring_left[written_count % RING_SIZE] = s.left_in;
			ring_right[written_count % RING_SIZE] = s.right_in;
			written_count = written_count + 1'b1;
			predicted.left_out = s.left_in;
			predicted.right_out = s.right_in;
			if (rate == UNITY_STEP) begin
				engaged = 1'b0;
				bypassed++;
			end else begin
				wc = longint'(written_count);
				lo = (wc > RING_SIZE) ? wc - RING_SIZE : 0;
				hi = wc - 1;
				if (!engaged) begin
					read_pos = {start, {FRAC_W{1'b0}}};
					engaged = 1'b1;
				end
				idx = longint'(read_pos[POS_W-1:FRAC_W]);
				frac = longint'(read_pos[FRAC_W-1:0]);
				// Keep both taps inside the span that has been written and is still held.
				if (idx < lo) begin
					idx = lo;
					frac = 0;
				end else if (idx + 1 > hi) begin
					idx = (hi - 1 > lo) ? hi - 1 : lo;
					frac = 0;
				end
				p0 = idx % RING_SIZE;
				p1 = (idx + 1) % RING_SIZE;
				predicted.left_out = blend(ring_left[p0], ring_left[p1], frac);
				predicted.right_out = blend(ring_right[p0], ring_right[p1], frac);
				read_pos = read_pos + rate;
				pitched++;
			end
			pending_outputs.push_back(predicted);
		endfunction

		function void check_output(result_t r);
			result_t want;
			if (pending_outputs.size() == 0) begin
				report($sformatf("unexpected result left=%0d right=%0d",
					r.left_out, r.right_out));
				return;
			end
			want = pending_outputs.pop_front();
			if (r.left_out !== want.left_out || r.right_out !== want.right_out)
				report($sformatf(
					"result mismatch: expected left=%0d right=%0d, got left=%0d right=%0d",
					want.left_out, want.right_out, r.left_out, r.right_out));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic smp_valid;
	logic smp_ready;
	sample_t smp;
	logic res_valid;
	logic res_ready;
	result_t res;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	pitch_scoreboard tracker = new;
	bit steady;
	bit hold_request;
	int holds_done;
	int rate_settings;
	int samples_sent;

	varispeed_ring_pitch_shifter #(
		.RING_DEPTH(RING_SIZE),
		.CHANNELS  (2)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.smp_valid(smp_valid),
		.smp_ready(smp_ready),
		.smp      (smp),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #6 clk = ~clk;

	// Watch both handshakes at each edge; values read here are the ones before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (smp_valid && smp_ready)
				tracker.accept_sample(smp);
			if (res_valid && res_ready)
				tracker.check_output(res);
		end
	end

	// Number of idle cycles before the next transaction on either side.
	function automatic int quiet_cycles();
		int n;
		n = 0;
		if (steady)
			return 0;
		while ($urandom_range(99) < IDLE_PERCENT)
			n++;
		return n;
	endfunction

	function automatic sample_t random_sample();
		sample_t s;
		case ($urandom_range(9))
			0, 1: begin
				s.left_in = $urandom_range(1) ? SMP_MAX : SMP_MIN;
				s.right_in = $urandom_range(1) ? SMP_MAX : SMP_MIN;
			end
			2, 3: begin
				s.left_in = SAMPLE_W'(int'($urandom_range(512)) - 256);
				s.right_in = SAMPLE_W'(int'($urandom_range(512)) - 256);
			end
			default: begin
				s.left_in = SAMPLE_W'($urandom);
				s.right_in = SAMPLE_W'($urandom);
			end
		endcase
		return s;
	endfunction

	function automatic logic [RATE_W-1:0] random_rate();
		case ($urandom_range(19))
			0:       return RATE_STOPPED;
			1:       return RATE_TOP;
			2, 3:    return RATE_HALF;
			4, 5:    return RATE_FAST;
			6, 7, 8: return UNITY_STEP;
			9:       return $urandom_range(1) ? UNITY_STEP - 1'b1 : UNITY_STEP + 1'b1;
			default: return RATE_W'($urandom_range(RATE_FAST, RATE_HALF));
		endcase
	endfunction

	// Offer one sample, idling first at random, and return at the edge that takes it.
	task automatic send_sample(input sample_t s);
		int gap;
		gap = quiet_cycles();
		if (gap > 0) begin
			smp_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp_valid <= 1'b1;
		smp <= s;
		do @(posedge clk); while (!smp_ready);
		samples_sent++;
	endtask

	// Stop offering and wait until every predicted output has come back.
	task automatic drain_outputs();
		smp_valid <= 1'b0;
		do @(posedge clk); while (tracker.pending_outputs.size() != 0);
	endtask

	// Write the rate over APB while the block is idle, then read it back.
	task automatic write_rate(input logic [RATE_W-1:0] value);
		drain_outputs();
		repeat (RESULT_LATENCY + 2) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= RATE_STEP_ADDR;
		pwdata <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.rate = value;
		rate_settings++;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== APB_DW'(value))
			tracker.report($sformatf("rate readback: expected %0d, got %0d", value, prdata));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		int held;
		res_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				res_ready <= 1'b0;
				for (held = 0; held < HOLD_CYCLES; held++)
					@(posedge clk);
				holds_done++;
			end
			res_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// Stimulus: directed cases first, then phases of random samples at random rates.
	initial begin
		int phase;
		int n;
		int k;
		int random_sent;
		arst_n <= 1'b0;
		smp_valid <= 1'b0;
		smp <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Engaged from the very first sample: the read sits on the sample just written.
		write_rate(RATE_FAST);
		send_sample(sample_t'{SMP_MAX, SMP_MIN});
		send_sample(sample_t'{SMP_MIN, SMP_MAX});
		send_sample(sample_t'{24'sd0, -24'sd1});
		send_sample(sample_t'{SMP_ODD, SMP_EVN});

		// Bypass passes samples through and disengages.
		write_rate(UNITY_STEP);
		send_sample(sample_t'{SMP_MAX, SMP_MIN});
		send_sample(sample_t'{-24'sd1, 24'sd0});
		send_sample(sample_t'{SMP_EVN, SMP_ODD});

		// Half speed re-engages at the current sample; full-scale odd steps test rounding.
		write_rate(RATE_HALF);
		for (k = 0; k < 4; k++) begin
			send_sample(sample_t'{SMP_MAX, SMP_MIN});
			send_sample(sample_t'{SMP_MIN, SMP_MAX});
		end

		// A zero rate freezes the read; the largest rate runs ahead into the clamp.
		write_rate(RATE_STOPPED);
		send_sample(sample_t'{24'sd1, -24'sd1});
		send_sample(sample_t'{SMP_MAX, SMP_MIN});
		send_sample(sample_t'{-24'sd2, 24'sd3});
		write_rate(RATE_TOP);
		send_sample(sample_t'{SMP_MIN, SMP_MAX});
		send_sample(sample_t'{24'sd7, -24'sd7});
		send_sample(sample_t'{SMP_ODD, SMP_EVN});

		phase = 0;
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			n = $urandom_range(140, 40);
			write_rate(random_rate());
			steady = (phase == 2);
			for (k = 0; k < n && random_sent < RANDOM_ITEMS; k++) begin
				if (phase == 4 && k == n / 2)
					hold_request = 1'b1;
				if (phase == 6 && k == n / 2)
					drain_outputs();
				send_sample(random_sample());
				random_sent++;
			end
			steady = 1'b0;
			phase++;
		end

		// Let the last results drain, then wait on and check that none is still outstanding.
		smp_valid <= 1'b0;
		while (tracker.pending_outputs.size() != 0)
			@(posedge clk);
		repeat (RESULT_LATENCY + 10) @(posedge clk);
		if (tracker.pending_outputs.size() != 0)
			tracker.report($sformatf("%0d expected results never arrived",
				tracker.pending_outputs.size()));

		$display("Ran %0d samples (%0d pitched, %0d bypassed) over %0d rate settings.",
			samples_sent, tracker.pitched, tracker.bypassed, rate_settings);
		$display("Receiver hold-offs: %0d; failures: %0d.", holds_done, tracker.failures);
		if (tracker.failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2000000;
		$display("Timed out with %0d results outstanding.", tracker.pending_outputs.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
